>>> hw/rtl/crsf_pkg.sv
// Package with payload types and constants of the CRSF frame receiver.
`timescale 1ns / 1ps
package crsf_pkg;
  localparam logic [7:0] SyncByte    = 8'hC8;
  localparam logic [7:0] TypeRc      = 8'h16;
  localparam logic [7:0] TypeLink    = 8'h14;
  localparam logic [7:0] RcLen       = 8'd24;
  localparam logic [7:0] LinkLen     = 8'd12;
  localparam logic [7:0] CrcPoly     = 8'hD5;
  localparam int unsigned NumChannels = 16;

  localparam logic [1:0] KindChannel = 2'd0;
  localparam logic [1:0] KindLink    = 2'd1;
  localparam logic [1:0] KindTick    = 2'd2;

  localparam logic [2:0] RegRawMin   = 3'd0;
  localparam logic [2:0] RegRawMax   = 3'd1;
  localparam logic [2:0] RegOutMin   = 3'd2;
  localparam logic [2:0] RegOutMax   = 3'd3;
  localparam logic [2:0] RegFailsafe = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [3:0]        channel_index;
    logic [11:0]       channel_value;
    logic [7:0]        rssi_ant1;
    logic [7:0]        rssi_ant2;
    logic [7:0]        link_quality;
    logic signed [7:0] signal_noise;
    logic [7:0]        radio_mode;
    logic [7:0]        transmit_power;
    logic              link_ok;
    logic              last;
  } out_item_t;

  function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage

>>> hw/rtl/crsf_rc_frame_receiver.sv
// Top level of the CRSF frame receiver: frame store, CRC, channel mapping and failsafe.
`timescale 1ns / 1ps
// The receiver takes one item at a time. A byte passes through the byte state. After
// a tick, the next item waits until the tick's result has left the output register.
// The closing byte of a good RC frame starts a channel pass that reads the frame store
// one byte at a time, 22 reads in all, to unpack the sixteen 11-bit channels. Each
// channel then passes through a restoring divider (24 steps plus setup and finish)
// and the output register, where output stalls can hold it. The divider sets the rate
// of a channel burst.
module crsf_rc_frame_receiver #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crsf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crsf_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  localparam int unsigned AW = $clog2(MAX_FRAME);
  localparam int unsigned CW = $clog2(MAX_FRAME + 1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StByte  = 7'b0000010,
    StRead  = 7'b0000100,
    StUnpk  = 7'b0001000,
    StDiv   = 7'b0010000,
    StOut   = 7'b0100000,
    StLink  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] mem [MAX_FRAME];
  logic [7:0] rdata_q;
  logic [AW-1:0] raddr;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0] flen_q, flen_d, crc_q, crc_d, type_q, type_d;
  logic [15:0] ms_q, ms_d;
  logic seen_q, seen_d;
  logic [7:0] st_q [6];
  logic [7:0] st_d [6];
  logic [10:0] raw_min_q, raw_max_q;
  logic [11:0] out_min_q, out_max_q;
  logic [15:0] fs_q;
  logic [7:0] byte_q, byte_d;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [3:0] ch_q, ch_d;
  logic [4:0] pos_q, pos_d;
  logic [4:0] rd_idx_q, rd_idx_d;
  logic [23:0] acc_q, acc_d;
  logic [4:0] nb_q, nb_d;
  logic [10:0] raw_q, raw_d;
  logic [23:0] quo_q, quo_d, num_q, num_d;
  logic [24:0] rem_q, rem_d;
  logic [4:0] dstep_q, dstep_d;
  logic neg_q, neg_d;
  logic [11:0] val_q, val_d;
  logic out_valid_q, out_valid_d;
  crsf_pkg::out_item_t out_q, out_d;
  logic [1:0] kind_q, kind_d;

  logic signed [12:0] dnum_s, dden_s;
  logic signed [12:0] dout_s;
  logic signed [25:0] prod_s;
  logic [12:0] den_abs;
  logic signed [15:0] v_s;
  logic [24:0] rem_sh;
  logic link_now;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= byte_q;
    end
    rdata_q <= mem[raddr];
  end

  assign dden_s = $signed({2'b0, raw_max_q}) - $signed({2'b0, raw_min_q});
  assign dnum_s = $signed({2'b0, raw_q}) - $signed({2'b0, raw_min_q});
  assign dout_s = $signed({1'b0, out_max_q}) - $signed({1'b0, out_min_q});
  assign prod_s = dnum_s * dout_s;
  assign den_abs = dden_s[12] ? 13'(-dden_s) : 13'(dden_s);
  assign rem_sh = {rem_q[23:0], num_q[23]};
  assign link_now = seen_q && (ms_q < fs_q);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; flen_d = flen_q; crc_d = crc_q; type_d = type_q;
    ms_d = ms_q; seen_d = seen_q; st_d = st_q; byte_d = byte_q;
    wr_en = 1'b0; wr_addr = cnt_q[AW-1:0]; raddr = '0;
    ch_d = ch_q; pos_d = pos_q; rd_idx_d = rd_idx_q; acc_d = acc_q; nb_d = nb_q;
    raw_d = raw_q; quo_d = quo_q; num_d = num_q; rem_d = rem_q;
    dstep_d = dstep_q; neg_d = neg_q; val_d = val_q; kind_d = kind_q;
    out_valid_d = out_valid_q; out_d = out_q;
    v_s = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.req_type) begin
            if (ms_q != 16'hFFFF) ms_d = ms_q + 16'd1;
            kind_d = crsf_pkg::KindTick;
            state_d = StLink;
          end else begin
            byte_d = in_data_i.rx_byte;
            state_d = StByte;
          end
        end
      end
      StByte: begin
        state_d = StIdle;
        if (cnt_q == '0 && byte_q != crsf_pkg::SyncByte) begin
          state_d = StIdle;
        end else if (cnt_q >= CW'(MAX_FRAME)) begin
          cnt_d = '0;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CW'(1)) begin
            flen_d = byte_q;
            crc_d = '0;
            if (byte_q < 8'd2 || (9'd2 + {1'b0, byte_q}) > 9'(MAX_FRAME)) cnt_d = '0;
          end else if (cnt_q >= CW'(2)) begin
            if (cnt_q == CW'(2)) type_d = byte_q;
            if ({1'b0, cnt_q} == (CW+1)'(flen_q) + (CW+1)'(1)) begin
              cnt_d = '0;
              if (crc_q == byte_q) begin
                if (type_q == crsf_pkg::TypeRc && flen_q == crsf_pkg::RcLen) begin
                  ch_d = '0; pos_d = '0; rd_idx_d = '0; nb_d = '0; acc_d = '0;
                  seen_d = 1'b1; ms_d = '0; kind_d = crsf_pkg::KindChannel;
                  state_d = StRead;
                end else if (type_q == crsf_pkg::TypeLink &&
                             flen_q == crsf_pkg::LinkLen) begin
                  pos_d = 5'd0; kind_d = crsf_pkg::KindLink;
                  state_d = StRead;
                end
              end
            end else begin
              crc_d = crsf_pkg::crc_byte(crc_q, byte_q);
            end
          end
        end
      end
      StRead: begin
        if (kind_q == crsf_pkg::KindLink) begin
          raddr = AW'(pos_q + 5'd3);
        end else begin
          raddr = AW'(rd_idx_q + 5'd3);
        end
        state_d = StUnpk;
      end
      StUnpk: begin
        if (kind_q == crsf_pkg::KindLink && type_q == crsf_pkg::TypeLink) begin
          case (pos_q)
            5'd0: st_d[0] = rdata_q;
            5'd1: st_d[1] = rdata_q;
            5'd2: st_d[2] = rdata_q;
            5'd3: st_d[3] = rdata_q;
            5'd5: st_d[4] = rdata_q;
            5'd6: st_d[5] = rdata_q;
            default: ;
          endcase
          if (pos_q == 5'd6) begin
            state_d = StLink;
          end else begin
            pos_d = pos_q + 5'd1;
            state_d = StRead;
          end
        end else begin
          acc_d = acc_q | (24'(rdata_q) << nb_q);
          nb_d = nb_q + 5'd8;
          rd_idx_d = rd_idx_q + 5'd1;
          if (nb_q + 5'd8 >= 5'd11) begin
            raw_d = acc_d[10:0];
            acc_d = acc_d >> 11;
            nb_d = nb_q + 5'd8 - 5'd11;
            state_d = StDiv;
            dstep_d = '0;
          end else begin
            state_d = StRead;
          end
        end
      end
      StDiv: begin
        if (dstep_q == 5'd0) begin
          neg_d = prod_s[25] ^ dden_s[12];
          num_d = prod_s[25] ? 24'(-prod_s) : 24'(prod_s);
          rem_d = '0; quo_d = '0;
          dstep_d = 5'd1;
          if (dden_s == '0) dstep_d = 5'd25;
        end else if (dstep_q <= 5'd24) begin
          if (rem_sh >= {12'b0, den_abs}) begin
            rem_d = rem_sh - {12'b0, den_abs};
            quo_d = {quo_q[22:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[22:0], 1'b0};
          end
          num_d = num_q << 1;
          dstep_d = dstep_q + 5'd1;
        end else begin
          if (dden_s == '0) v_s = $signed({4'b0, out_min_q});
          else if (neg_q) v_s = -$signed({2'b0, quo_q[13:0]}) + $signed({4'b0, out_min_q});
          else v_s = $signed({2'b0, quo_q[13:0]}) + $signed({4'b0, out_min_q});
          if (quo_q[23:14] != '0 && dden_s != '0) begin
            v_s = neg_q ? -16'sd16384 : 16'sd16383;
          end
          if (v_s < $signed({4'b0, out_min_q})) val_d = out_min_q;
          else if (v_s > $signed({4'b0, out_max_q})) val_d = out_max_q;
          else val_d = v_s[11:0];
          kind_d = crsf_pkg::KindChannel;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = '{crsf_pkg::KindChannel, ch_q, val_q, st_q[0], st_q[1], st_q[2],
                    st_q[3], st_q[4], st_q[5], link_now,
                    ch_q == 4'(crsf_pkg::NumChannels - 1)};
          ch_d = ch_q + 4'd1;
          state_d = (ch_q == 4'(crsf_pkg::NumChannels - 1)) ? StIdle :
                    ((nb_q >= 5'd11) ? StDiv : StRead);
          if (nb_q >= 5'd11) begin
            raw_d = acc_q[10:0];
            acc_d = acc_q >> 11;
            nb_d = nb_q - 5'd11;
            dstep_d = '0;
          end
        end
      end
      StLink: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = '{kind_q, 4'd0, 12'd0, st_q[0], st_q[1], st_q[2],
                    st_q[3], st_q[4], st_q[5], link_now, 1'b1};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; ms_q <= '0; seen_q <= 1'b0;
      for (int i = 0; i < 6; i++) st_q[i] <= '0;
      raw_min_q <= 11'd172; raw_max_q <= 11'd1811;
      out_min_q <= 12'd1000; out_max_q <= 12'd2000; fs_q <= 16'd250;
      out_valid_q <= 1'b0; kind_q <= crsf_pkg::KindTick;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ms_q <= ms_d; seen_q <= seen_d;
      st_q <= st_d; out_valid_q <= out_valid_d; kind_q <= kind_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          crsf_pkg::RegRawMin:   raw_min_q <= cfg_data_i[10:0];
          crsf_pkg::RegRawMax:   raw_max_q <= cfg_data_i[10:0];
          crsf_pkg::RegOutMin:   out_min_q <= cfg_data_i[11:0];
          crsf_pkg::RegOutMax:   out_max_q <= cfg_data_i[11:0];
          crsf_pkg::RegFailsafe: fs_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flen_q <= flen_d; crc_q <= crc_d; type_q <= type_d; byte_q <= byte_d;
    ch_q <= ch_d; pos_q <= pos_d; rd_idx_q <= rd_idx_d; acc_q <= acc_d; nb_q <= nb_d;
    raw_q <= raw_d; quo_q <= quo_d; num_q <= num_d; rem_q <= rem_d;
    dstep_q <= dstep_d; neg_q <= neg_d; val_q <= val_d; out_q <= out_d;
  end
endmodule

>>> hw/rtl/crsf_checker.sv
// Port checker for the CRSF frame receiver and its bind.
`timescale 1ns / 1ps
module crsf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input crsf_pkg::out_item_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_kind == crsf_pkg::KindChannel ||
                     out_data_o.result_kind == crsf_pkg::KindLink ||
                     out_data_o.result_kind == crsf_pkg::KindTick))
    else $error("bad result kind");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind != crsf_pkg::KindChannel |-> out_data_o.last)
    else $error("single result without last");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted two items back to back");
endmodule

bind crsf_rc_frame_receiver crsf_checker u_crsf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
